// File: design/dcf_pkg.sv
// ----------------------------------------------------------------------------
// Channel crossfader package
// Widths, command codes, queue sizing and the command word type.
// ----------------------------------------------------------------------------
package dcf_pkg;

   localparam int CMD_W    = 2;
   localparam int CHAN_W   = 9;
   localparam int LEVEL_W  = 8;
   localparam int DUR_W    = 24;
   localparam int PROD_W   = LEVEL_W + DUR_W;

   localparam int CHANNELS_DEFAULT = 512;

   // command queue between intake and execution; depth is a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STAGE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [CHAN_W-1:0]  channel;
      logic [LEVEL_W-1:0] level;
      logic               in_range;
   } cmd_word_type;

endpackage

// File: design/dmx_channel_crossfader_top.sv
// ----------------------------------------------------------------------------
// Lighting channel crossfader
// Stages target levels, commits crossfades and reads interpolated levels.
// ----------------------------------------------------------------------------
//
//   port group   direction   handshake          word
//   req_*        in          push / full        command, channel, level_in
//   rsp_*        out         pop / empty        channel_out, level_out, fade_done
//   csr_*        in          valid / ready      fade duration in ms ticks
//
// Steps: tick and stage words retire straight from the idle state. A read
//   goes fetch, multiply, apply when the fade is done, straight to apply
//   for an out-of-range channel, and via the 8-step divider otherwise.
// A commit walks all CHANNELS entries of the start/end RAM, one channel at a
//   time, taking the divider path only while the fade is not done.
// Reset: a clearing pass over all CHANNELS entries zeroes both stores; req_full
//   stays high through it. csr writes are taken at any time.
// Stalls: a 4-word command queue decouples intake from execution, and the
//   result register lets work continue until the next read needs it; a read
//   holds its last cycle while an unpopped result sits in that register.
//
module dmx_channel_crossfader_top
   import dcf_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   // command words
   input  logic               req_push,
   output logic               req_full,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [CHAN_W-1:0]  req_channel,
   input  logic [LEVEL_W-1:0] req_level_in,

   // read results
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CHAN_W-1:0]  rsp_channel_out,
   output logic [LEVEL_W-1:0] rsp_level_out,
   output logic               rsp_fade_done,

   // fade duration register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [DUR_W-1:0]   csr_wdata
);

   cmd_word_type word;
   logic         word_valid;
   logic         word_pop;
   logic         hold;

   // intake: classifies channel range, buffers words
   dcf_front #(.CHANNELS(CHANNELS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_command  (req_command),
      .req_channel  (req_channel),
      .req_level_in (req_level_in),
      .req_full     (req_full),
      .hold         (hold),
      .word_valid   (word_valid),
      .word_pop     (word_pop),
      .word         (word)
   );

   // execution: stores, ms counter, interpolation, result register
   dcf_back #(.CHANNELS(CHANNELS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .word_valid      (word_valid),
      .word            (word),
      .word_pop        (word_pop),
      .hold            (hold),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_channel_out (rsp_channel_out),
      .rsp_level_out   (rsp_level_out),
      .rsp_fade_done   (rsp_fade_done)
   );

endmodule

// File: design/dcf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dcf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/dcf_divider.sv
// ----------------------------------------------------------------------------
// Crossfade step divider
// Restoring divider, one quotient bit per cycle. Needs dividend < divisor << 8.
// ----------------------------------------------------------------------------
module dcf_divider
   import dcf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PROD_W-1:0]  dividend,
   input  logic [DUR_W-1:0]   divisor,
   output logic               done,
   output logic [LEVEL_W-1:0] quotient
);

   localparam int STEP_W = $clog2(LEVEL_W + 1);

   logic [DUR_W-1:0]   rem_ff, rem_in;
   logic [LEVEL_W-1:0] low_ff, low_in;
   logic [LEVEL_W-1:0] quot_ff, quot_in;
   logic [DUR_W-1:0]   dvs_ff, dvs_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [DUR_W:0] trial;
   logic [DUR_W:0] diff;
   logic           ge;

   always_comb begin
      trial   = {rem_ff, low_ff[LEVEL_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[PROD_W-1:LEVEL_W];
         low_in  = dividend[LEVEL_W-1:0];
         dvs_in  = divisor;
         quot_in = '0;
         step_in = STEP_W'(LEVEL_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
         low_in  = {low_ff[LEVEL_W-2:0], 1'b0};
         quot_in = {quot_ff[LEVEL_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: design/dcf_front.sv
// ----------------------------------------------------------------------------
// Crossfader intake
// Accepts command words, flags channel range, queues them for execution.
// ----------------------------------------------------------------------------
module dcf_front
   import dcf_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [CHAN_W-1:0]  req_channel,
   input  logic [LEVEL_W-1:0] req_level_in,
   output logic               req_full,
   input  logic               hold,
   output logic               word_valid,
   input  logic               word_pop,
   output cmd_word_type       word
);

   localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);

   cmd_word_type        queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push_ok;
   cmd_word_type        new_word;

   always_comb begin
      new_word.command  = req_command;
      new_word.channel  = req_channel;
      new_word.level    = req_level_in;
      new_word.in_range = ({1'b0, req_channel} < CHAN_LIMIT);
   end

   assign req_full   = hold || (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign push_ok    = req_push && !req_full;
   assign word_valid = (count_ff != '0);
   assign word       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = word_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !word_pop) begin
         count_in = count_ff + (QUEUE_AW + 1)'(1);
      end else if (!push_ok && word_pop) begin
         count_in = count_ff - (QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= new_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
      else $error("command queue count beyond depth");

endmodule

// File: design/dcf_back.sv
// ----------------------------------------------------------------------------
// Crossfader execution
// Level stores, ms counter, interpolation sequencer and result register.
// ----------------------------------------------------------------------------
module dcf_back
   import dcf_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [DUR_W-1:0]   csr_wdata,
   input  logic               word_valid,
   input  cmd_word_type       word,
   output logic               word_pop,
   output logic               hold,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CHAN_W-1:0]  rsp_channel_out,
   output logic [LEVEL_W-1:0] rsp_level_out,
   output logic               rsp_fade_done
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CHANNELS - 1);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_FETCH   = 3'd2;
   localparam logic [2:0] S_MUL     = 3'd3;
   localparam logic [2:0] S_DIVGO   = 3'd4;
   localparam logic [2:0] S_DIVWAIT = 3'd5;
   localparam logic [2:0] S_APPLY   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               commit_ff, commit_in;
   logic [DUR_W-1:0]   elapsed_ff, elapsed_in;
   logic [DUR_W-1:0]   fade_ff, fade_in;
   logic               out_valid_ff, out_valid_in;

   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0] start_ff, start_in;
   logic [LEVEL_W-1:0] staged_ff, staged_in;
   logic               rise_ff, rise_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [CHAN_W-1:0]  out_chan_ff, out_chan_in;
   logic [LEVEL_W-1:0] out_level_ff, out_level_in;
   logic               out_done_ff, out_done_in;

   logic                  clearing;
   logic                  finished;
   logic                  out_load;
   logic                  stage_wr;
   logic                  fade_wr;
   logic [2*LEVEL_W-1:0]  fade_rd;
   logic [LEVEL_W-1:0]    staged_rd;
   logic [LEVEL_W-1:0]    rd_start;
   logic [LEVEL_W-1:0]    rd_end;
   logic [LEVEL_W-1:0]    diff;
   logic                  div_start;
   logic                  div_done;
   logic [LEVEL_W-1:0]    quotient;

   assign clearing  = (state_ff == S_CLEAR);
   assign hold      = clearing;
   assign csr_ready = 1'b1;
   assign finished  = (elapsed_ff >= fade_ff);
   assign word_pop  = (state_ff == S_IDLE) && word_valid;
   assign rd_start  = fade_rd[2*LEVEL_W-1:LEVEL_W];
   assign rd_end    = fade_rd[LEVEL_W-1:0];
   assign div_start = (state_ff == S_DIVGO);

   // staging store: cleared after reset, written by stage words
   assign stage_wr = clearing || (word_pop && word.command == CMD_STAGE && word.in_range);

   dcf_ram #(.WIDTH(LEVEL_W), .DEPTH(CHANNELS)) u_staged_ram (
      .clock   (clock),
      .wr_en   (stage_wr),
      .wr_addr (clearing ? addr_ff : word.channel[ADDR_W-1:0]),
      .wr_data (clearing ? '0 : word.level),
      .rd_en   (state_ff == S_FETCH),
      .rd_addr (addr_ff),
      .rd_data (staged_rd)
   );

   // start/end pair store, rewritten one channel at a time by a commit
   assign fade_wr = clearing || ((state_ff == S_APPLY) && commit_ff);

   dcf_ram #(.WIDTH(2 * LEVEL_W), .DEPTH(CHANNELS)) u_fade_ram (
      .clock   (clock),
      .wr_en   (fade_wr),
      .wr_addr (addr_ff),
      .wr_data (clearing ? '0 : {level_ff, staged_ff}),
      .rd_en   (state_ff == S_FETCH),
      .rd_addr (addr_ff),
      .rd_data (fade_rd)
   );

   dcf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (fade_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      diff = (rd_end >= rd_start) ? rd_end - rd_start : rd_start - rd_end;
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      commit_in    = commit_ff;
      elapsed_in   = elapsed_ff;
      fade_in      = csr_valid ? csr_wdata : fade_ff;
      chan_in      = chan_ff;
      level_in     = level_ff;
      start_in     = start_ff;
      staged_in    = staged_ff;
      rise_in      = rise_ff;
      prod_in      = prod_ff;
      out_load     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            if (addr_ff == ADDR_LAST) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (word_valid) begin
               case (word.command)
                  CMD_TICK: begin
                     if (elapsed_ff < fade_ff) begin
                        elapsed_in = elapsed_ff + DUR_W'(1);
                     end
                  end
                  CMD_STAGE: begin
                     // store write happens on the RAM port
                  end
                  CMD_COMMIT: begin
                     commit_in = 1'b1;
                     addr_in   = '0;
                     state_in  = S_FETCH;
                  end
                  CMD_READ: begin
                     commit_in = 1'b0;
                     chan_in   = word.channel;
                     if (word.in_range) begin
                        addr_in  = word.channel[ADDR_W-1:0];
                        state_in = S_FETCH;
                     end else begin
                        level_in = '0;
                        state_in = S_APPLY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            start_in  = rd_start;
            staged_in = staged_rd;
            rise_in   = (rd_end >= rd_start);
            prod_in   = PROD_W'(diff) * PROD_W'(elapsed_ff);
            if (finished) begin
               level_in = rd_end;
               state_in = S_APPLY;
            end else begin
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            state_in = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (div_done) begin
               level_in = rise_ff ? start_ff + quotient : start_ff - quotient;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (commit_ff) begin
               if (addr_ff == ADDR_LAST) begin
                  elapsed_in = '0;
                  state_in   = S_IDLE;
               end else begin
                  addr_in  = addr_ff + ADDR_W'(1);
                  state_in = S_FETCH;
               end
            end else if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_chan_in  = out_chan_ff;
      out_level_in = out_level_ff;
      out_done_in  = out_done_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_chan_in  = chan_ff;
         out_level_in = level_ff;
         out_done_in  = finished;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         commit_ff    <= 1'b0;
         elapsed_ff   <= '0;
         fade_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         commit_ff    <= commit_in;
         elapsed_ff   <= elapsed_in;
         fade_ff      <= fade_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff      <= chan_in;
      level_ff     <= level_in;
      start_ff     <= start_in;
      staged_ff    <= staged_in;
      rise_ff      <= rise_in;
      prod_ff      <= prod_in;
      out_chan_ff  <= out_chan_in;
      out_level_ff <= out_level_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_channel_out = out_chan_ff;
   assign rsp_level_out   = out_level_ff;
   assign rsp_fade_done   = out_done_ff;

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !word_pop)
      else $error("command word taken during store clear");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      word_pop |-> word_valid)
      else $error("pop from empty command queue");

   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && commit_ff && addr_ff == ADDR_LAST) |=> (elapsed_ff == '0))
      else $error("elapsed counter not cleared after commit walk");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVWAIT))
      else $error("divider finished outside its wait state");

endmodule

// File: sim/crossfade_level_checker.sv
// ----------------------------------------------------------------------------
// Crossfade level checker
// Watches the command, result and fade duration channels, keeps its own copy
// of the staged/start/end levels and the ms counter, predicts every read
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module crossfade_level_checker
   import dcf_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_push,
   input  logic               req_full,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [CHAN_W-1:0]  req_channel,
   input  logic [LEVEL_W-1:0] req_level_in,

   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic [CHAN_W-1:0]  rsp_channel_out,
   input  logic [LEVEL_W-1:0] rsp_level_out,
   input  logic               rsp_fade_done,

   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [DUR_W-1:0]   csr_wdata,

   output int                 mismatches,
   output int                 outstanding,
   output int                 reads_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic [LEVEL_W-1:0] level;
      logic               done;
   } read_result_type;

   logic [LEVEL_W-1:0] staged_lv [CHANNELS];
   logic [LEVEL_W-1:0] start_lv  [CHANNELS];
   logic [LEVEL_W-1:0] end_lv    [CHANNELS];
   logic [DUR_W-1:0]   elapsed_ms;
   logic [DUR_W-1:0]   fade_ms;

   read_result_type levels_due [$];
   int              bad_count;
   int              read_count;

   function automatic logic fade_over();
      return (fade_ms == '0) || (elapsed_ms >= fade_ms);
   endfunction

   // start +/- |end - start| * elapsed / fade, magnitude truncated
   function automatic logic [LEVEL_W-1:0] interp_level(logic [CHAN_W-1:0] ch);
      logic [LEVEL_W-1:0] s;
      logic [LEVEL_W-1:0] e;
      logic [PROD_W-1:0]  span;
      logic [PROD_W-1:0]  part;
      if (ch >= CHANNELS) return '0;
      s = start_lv[ch];
      e = end_lv[ch];
      if (fade_over()) return e;
      span = (e >= s) ? PROD_W'(e - s) : PROD_W'(s - e);
      part = (span * PROD_W'(elapsed_ms)) / PROD_W'(fade_ms);
      return (e >= s) ? s + part[LEVEL_W-1:0] : s - part[LEVEL_W-1:0];
   endfunction

   always @(posedge clock) begin
      read_result_type seen;
      read_result_type want;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            staged_lv[i] = '0;
            start_lv[i]  = '0;
            end_lv[i]    = '0;
         end
         elapsed_ms = '0;
         fade_ms    = '0;
         levels_due.delete();
         bad_count  = 0;
         read_count = 0;
      end else begin
         if (csr_valid && csr_ready)
            fade_ms = csr_wdata;

         if (rsp_pop && !rsp_empty) begin
            seen = '{rsp_channel_out, rsp_level_out, rsp_fade_done};
            if (levels_due.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("%t: result word with none pending: chan %0d level %0d done %0b",
                           $realtime, seen.channel, seen.level, seen.done);
            end else begin
               want = levels_due.pop_front();
               read_count++;
               if (seen.channel !== want.channel || seen.level !== want.level ||
                   seen.done !== want.done) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display("%t: read mismatch: exp chan %0d level %0d done %0b, got chan %0d level %0d done %0b",
                              $realtime, want.channel, want.level, want.done,
                              seen.channel, seen.level, seen.done);
               end
            end
         end

         if (req_push && !req_full) begin
            case (req_command)
               CMD_TICK: begin
                  if (elapsed_ms < fade_ms) elapsed_ms = elapsed_ms + 1'b1;
               end
               CMD_STAGE: begin
                  if (req_channel < CHANNELS) staged_lv[req_channel] = req_level_in;
               end
               CMD_COMMIT: begin
                  // each channel's level is taken before its own entries change
                  for (int i = 0; i < CHANNELS; i++) begin
                     start_lv[i] = interp_level(CHAN_W'(i));
                     end_lv[i]   = staged_lv[i];
                  end
                  elapsed_ms = '0;
               end
               CMD_READ: begin
                  levels_due.push_back('{req_channel, interp_level(req_channel),
                                         fade_over()});
               end
               default: ;
            endcase
         end
      end
      mismatches    <= bad_count;
      outstanding   <= levels_due.size();
      reads_checked <= read_count;
   end

endmodule

// File: sim/dmx_channel_crossfader_top_test.sv
// ----------------------------------------------------------------------------
// Channel crossfader testbench
// Directed fade sequences, then random stage/commit/tick/read scenes under
// several fade durations and handshake idling patterns; a separate checker
// predicts and compares every read result.
// ----------------------------------------------------------------------------
module dmx_channel_crossfader_top_test;
   import dcf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS     = CHANNELS_DEFAULT;
   localparam int ITEM_TARGET  = 2000;
   localparam int PHASES       = 6;
   // worst case commit: every channel on the slow divider path
   localparam int DRAIN_CYCLES = CHANNELS * 14 + 64;
   // bound for the slowest legal run, with a wide margin
   localparam int CYCLE_LIMIT  = 2_500_000;

   logic               clock;
   logic               reset        = 1'b1;
   logic               req_push     = 1'b0;
   logic               req_full;
   logic [CMD_W-1:0]   req_command  = CMD_TICK;
   logic [CHAN_W-1:0]  req_channel  = '0;
   logic [LEVEL_W-1:0] req_level_in = '0;
   logic               rsp_empty;
   logic               rsp_pop      = 1'b0;
   logic [CHAN_W-1:0]  rsp_channel_out;
   logic [LEVEL_W-1:0] rsp_level_out;
   logic               rsp_fade_done;
   logic               csr_valid    = 1'b0;
   logic               csr_ready;
   logic [DUR_W-1:0]   csr_wdata    = '0;

   int send_idle_pct = 28;     // chance per word of an idle cycle before it
   int recv_idle_pct = 55;     // chance per cycle that pop stays low
   int words_sent    = 0;
   int commits_sent  = 0;
   int cycle_count   = 0;
   int mismatches;
   int outstanding;
   int reads_checked;

   // channels a scene stages; its body reads pick one of them half the time
   logic [CHAN_W-1:0] hot_chan [8];

   dmx_channel_crossfader_top #(.CHANNELS(CHANNELS)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_channel     (req_channel),
      .req_level_in    (req_level_in),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_channel_out (rsp_channel_out),
      .rsp_level_out   (rsp_level_out),
      .rsp_fade_done   (rsp_fade_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   crossfade_level_checker #(.CHANNELS(CHANNELS)) i_level_check (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_channel     (req_channel),
      .req_level_in    (req_level_in),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_channel_out (rsp_channel_out),
      .rsp_level_out   (rsp_level_out),
      .rsp_fade_done   (rsp_fade_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .reads_checked   (reads_checked)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: pop held low at random, per cycle
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d reads still pending", cycle_count, outstanding);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one command word and hold it until the block takes it. Push is
   // left high afterwards, so back-to-back words need no extra edge; an idle
   // cycle drops it first.
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                            logic [LEVEL_W-1:0] lvl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push     <= 1'b1;
      req_command  <= cmd;
      req_channel  <= ch;
      req_level_in <= lvl;
      @(posedge clock);
      while (req_full) @(posedge clock);
      words_sent++;
      if (cmd == CMD_COMMIT) commits_sent++;
   endtask

   // Close a phase: a trailing read retires only after everything queued
   // ahead of it, then wait out every pending result plus a full commit walk.
   task automatic settle();
      send_word(CMD_READ, CHAN_W'($urandom_range(CHANNELS - 1)), LEVEL_W'($urandom));
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // called with the block idle, except the first write during the post-reset clear
   task automatic write_fade(logic [DUR_W-1:0] ms);
      csr_valid <= 1'b1;
      csr_wdata <= ms;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // One lighting scene: stage a few targets, commit, then a mix of ticks
   // and reads with some stray stages and a little random noise.
   task automatic run_scene();
      int               n_body;
      int               pick;
      logic [CMD_W-1:0] cmd;
      for (int k = 0; k < 8; k++) hot_chan[k] = CHAN_W'($urandom_range(CHANNELS - 1));
      repeat ($urandom_range(6, 1))
         send_word(CMD_STAGE, hot_chan[$urandom_range(7)], LEVEL_W'($urandom_range(255)));
      send_word(CMD_COMMIT, CHAN_W'($urandom), LEVEL_W'($urandom));
      n_body = $urandom_range(100, 30);
      for (int k = 0; k < n_body; k++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // noise, commits mostly thinned out since each walks every channel
            cmd = CMD_W'($urandom_range(3));
            if (cmd == CMD_COMMIT && $urandom_range(3) != 0) cmd = CMD_READ;
            send_word(cmd, CHAN_W'($urandom), LEVEL_W'($urandom));
         end else if (pick < 55) begin
            send_word(CMD_TICK, CHAN_W'($urandom), LEVEL_W'($urandom));
         end else if (pick < 63) begin
            send_word(CMD_STAGE, hot_chan[$urandom_range(7)], LEVEL_W'($urandom));
         end else if ($urandom_range(1) != 0) begin
            send_word(CMD_READ, hot_chan[$urandom_range(7)], LEVEL_W'($urandom));
         end else begin
            send_word(CMD_READ, CHAN_W'($urandom), LEVEL_W'($urandom));
         end
      end
   endtask

   initial begin
      logic [DUR_W-1:0] fade_plan [PHASES];
      int               goal;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: full-scale fade up, end-of-fade hold, fade down ----
      write_fade(DUR_W'(4));
      send_word(CMD_READ,   CHAN_W'(0),   LEVEL_W'(8'hff));  // reset state, mid-fade
      send_word(CMD_STAGE,  CHAN_W'(0),   LEVEL_W'(255));
      send_word(CMD_STAGE,  CHAN_W'(511), LEVEL_W'(200));
      send_word(CMD_STAGE,  CHAN_W'(256), LEVEL_W'(1));
      send_word(CMD_COMMIT, CHAN_W'(511), LEVEL_W'(0));
      send_word(CMD_READ,   CHAN_W'(0),   LEVEL_W'(0));      // elapsed zero
      send_word(CMD_TICK,   CHAN_W'(0),   LEVEL_W'(0));
      send_word(CMD_READ,   CHAN_W'(0),   LEVEL_W'(0));      // quarter way
      // three ticks reach the end, the fourth must hold the counter there
      repeat (4) send_word(CMD_TICK, CHAN_W'(511), LEVEL_W'(255));
      send_word(CMD_READ,   CHAN_W'(0),   LEVEL_W'(0));
      send_word(CMD_READ,   CHAN_W'(511), LEVEL_W'(0));
      send_word(CMD_STAGE,  CHAN_W'(0),   LEVEL_W'(0));
      send_word(CMD_COMMIT, CHAN_W'(0),   LEVEL_W'(255));
      send_word(CMD_TICK,   CHAN_W'(0),   LEVEL_W'(0));
      send_word(CMD_TICK,   CHAN_W'(0),   LEVEL_W'(0));
      send_word(CMD_READ,   CHAN_W'(0),   LEVEL_W'(0));      // downward, truncated
      settle();
      // duration cut below the elapsed count while fading: jumps to the end level
      write_fade(DUR_W'(1));
      send_word(CMD_READ,   CHAN_W'(0),   LEVEL_W'(0));
      send_word(CMD_READ,   CHAN_W'(511), LEVEL_W'(0));
      settle();
      // zero duration: every read is the end level, done set
      write_fade('0);
      send_word(CMD_COMMIT, CHAN_W'(0),   LEVEL_W'(0));
      send_word(CMD_READ,   CHAN_W'(256), LEVEL_W'(0));
      send_word(CMD_READ,   CHAN_W'(0),   LEVEL_W'(0));
      settle();

      // ---- random scenes, one fade duration per phase ----
      fade_plan[0] = DUR_W'(1);
      fade_plan[1] = DUR_W'(37);
      fade_plan[2] = '0;
      fade_plan[3] = DUR_W'(3);
      fade_plan[4] = '1;                                      // longest fade
      fade_plan[5] = DUR_W'($urandom_range(60, 5));
      for (int p = 0; p < PHASES; p++) begin
         // receiver-heavy idle, then sender-heavy, then none at all
         if (p < 2) begin
            send_idle_pct = 28;
            recv_idle_pct = 55;
         end else if (p < 4) begin
            send_idle_pct = 55;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_fade(fade_plan[p]);
         goal = words_sent + ITEM_TARGET / PHASES;
         while (words_sent < goal) run_scene();
         settle();
      end

      $display("Sent %0d command words with %0d commits, fades of 0 to %0d ms ticks",
               words_sent, commits_sent, 24'hffffff);
      $display("Checked %0d read results across three idling patterns, %0d mismatches",
               reads_checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
design/dcf_pkg.sv
design/dcf_ram.sv
design/dcf_divider.sv
design/dcf_front.sv
design/dcf_back.sv
design/dmx_channel_crossfader_top.sv
sim/crossfade_level_checker.sv
sim/dmx_channel_crossfader_top_test.sv
